// ----- rtl/lpr_pkg.sv -----
package lpr_pkg;

  localparam int MAX_WIDTH        = 4096;
  localparam int PIXEL_BITS       = 14;
  localparam int WEIGHT_FRAC_BITS = 19;
  localparam int WEIGHT_BITS      = 40;
  localparam int NUM_PRED         = 4;

  localparam int ERR_BITS  = PIXEL_BITS + 1;
  localparam int CFG_BITS  = 13;
  localparam int IDX_BITS  = $clog2(MAX_WIDTH);
  localparam int COL_BITS  = IDX_BITS + 1;
  localparam int ADDR_BITS = IDX_BITS + 1;
  localparam int RAM_DEPTH = 2 * MAX_WIDTH;
  localparam int RAM_BITS  = ERR_BITS + PIXEL_BITS;

  localparam int EST_BITS  = PIXEL_BITS + 3;
  localparam int PROD_BITS = WEIGHT_BITS + EST_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int P0_BITS   = SUM_BITS - WEIGHT_FRAC_BITS;
  localparam int SYM_BITS  = PIXEL_BITS + 2;
  localparam int NB_BITS   = $clog2(ERR_BITS + 1);
  localparam int LEN_BITS  = NB_BITS + 1;

  localparam int WORD_BITS  = 64;
  localparam int FREE_BITS  = 7;
  localparam int CNT_BITS   = 10;
  localparam int MAX_RES    = 4;
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_INIT =
    WEIGHT_BITS'((1 << WEIGHT_FRAC_BITS) / NUM_PRED);
  localparam logic [CFG_BITS-1:0] WIDTH_RESET = CFG_BITS'(MAX_WIDTH);

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [CNT_BITS-1:0]  repeat_count;
    logic                 last_word;
  } result_t;

endpackage

// ----- rtl/lpr_in_if.sv -----
interface lpr_in_if;
  import lpr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  end_of_image;

  modport source (output valid, output pixel, output end_of_image, input ready);
  modport sink (input valid, input pixel, input end_of_image, output ready);

endinterface

// ----- rtl/lpr_out_if.sv -----
interface lpr_out_if;
  import lpr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] word;
  logic [CNT_BITS-1:0]  repeat_count;
  logic                 last_word;

  modport source (output valid, output word, output repeat_count, output last_word,
                  input ready);
  modport sink (input valid, input word, input repeat_count, input last_word,
                output ready);

endinterface

// ----- rtl/lpr_ram.sv -----
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/lms_predict_rice_pixel_encoder_top.sv -----
// Lossless raster pixel encoder. Each input transaction carries one pixel in raster
// order; output transactions carry packed 64-bit code words (first code bit in the
// MSB), with repeat_count > 1 only for runs of all-zero words and last_word set on
// the flush word that closes an image (sent with the pixel flagged end_of_image).
// When a pixel is accepted the row read three columns ahead is issued and the four
// weight products are formed; the calc state finishes the blend, clamp, residual,
// weight update and row write; the west pixel and the weights loop back into the
// next pixel through that state. Each new row passes through a prefetch state in
// which the row memory is read for the first three north neighbours (entered from
// idle when a narrower width forces the new row before a pixel). After reset and
// after every end_of_image the row memory (8192 entries) is cleared one entry a
// cycle, taking no pixel until it is done. Code packing runs in the cycle after the
// arithmetic, into a 16-entry result queue; intake pauses while more than 8 results
// wait. image_width (cfg_wdata) is to be written only while the block is idle;
// the block does not enforce this; 0 acts as 1 and values above 4096 act as 4096.
module lms_predict_rice_pixel_encoder_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lpr_pkg::CFG_BITS-1:0] cfg_wdata,
  lpr_in_if.sink                       in_stream,
  lpr_out_if.source                    out_stream
);
  import lpr_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_CALC, ST_PREF} state_t;

  localparam logic [FREE_BITS-1:0] FULL_FREE = FREE_BITS'(WORD_BITS);

  // control and image state
  state_t                  state_r, state_nxt;
  logic [CFG_BITS-1:0]     width_r, width_nxt;
  logic [COL_BITS-1:0]     col_r, col_nxt;
  logic                    parity_r, parity_nxt;
  logic                    first_row_r, first_row_nxt;
  logic [ADDR_BITS-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [1:0]              pf_cnt_r, pf_cnt_nxt;
  logic                    rd_gate_r, rd_gate_nxt;
  logic signed [WEIGHT_BITS-1:0] weight_r [NUM_PRED];
  logic signed [WEIGHT_BITS-1:0] weight_nxt [NUM_PRED];
  // north window holds columns c-1 .. c+2 of the previous row, gated by width at use
  logic [PIXEL_BITS-1:0]   win_nw_r, win_nw_nxt;
  logic [PIXEL_BITS-1:0]   win_n_r, win_n_nxt;
  logic [PIXEL_BITS-1:0]   win_ne_r, win_ne_nxt;
  logic [PIXEL_BITS-1:0]   win_nn2_r, win_nn2_nxt;
  logic [PIXEL_BITS-1:0]   west_pix_r, west_pix_nxt;
  logic [ERR_BITS-1:0]     west_err_r, west_err_nxt;

  // pixel in flight (payload)
  logic [PIXEL_BITS-1:0]       cur_pix_r;
  logic                        cur_eoi_r;
  logic signed [EST_BITS-1:0]  est_r [NUM_PRED];
  logic signed [PROD_BITS-1:0] prod_r [NUM_PRED];

  // packing stage
  logic                    pk_v_r, pk_v_nxt;
  logic [SYM_BITS-1:0]     pk_sym_r;
  logic [NB_BITS-1:0]      pk_nb_r;
  logic                    pk_eoi_r;
  logic [WORD_BITS-1:0]    cache_r, cache_nxt;
  logic [FREE_BITS-1:0]    free_r, free_nxt;

  // result queue
  result_t                 fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]        count_r, count_nxt;

  // row memory port
  logic                    ram_we;
  logic [ADDR_BITS-1:0]    ram_waddr;
  logic [RAM_BITS-1:0]     ram_wdata;
  logic [ADDR_BITS-1:0]    ram_raddr;
  logic [RAM_BITS-1:0]     ram_rdata;
  logic [IDX_BITS-1:0]     rd_idx;

  // combinational terms
  logic [COL_BITS-1:0]     w_eff;
  logic [COL_BITS:0]       col_p3;
  logic [COL_BITS:0]       col_p1;
  logic                    need_roll;
  logic                    accept;
  logic                    pop;
  logic                    p3_in_row;
  logic [PIXEL_BITS-1:0]   ne_g;
  logic signed [EST_BITS-1:0]  est_c [NUM_PRED];
  logic signed [PROD_BITS-1:0] prod_c [NUM_PRED];
  logic [RAM_BITS-1:0]     nrd;
  logic [PIXEL_BITS-1:0]   neee_raw;
  logic [PIXEL_BITS-1:0]   neee;
  logic [ERR_BITS-1:0]     eneee;
  logic [PIXEL_BITS-1:0]   vmin, vmax;
  logic signed [SUM_BITS-1:0]  sum_c;
  logic signed [P0_BITS-1:0]   p0_c, curr_s, vmin_s, vmax_s;
  logic [PIXEL_BITS-1:0]   pred_c;
  logic signed [PIXEL_BITS:0]  d_c;
  logic [SYM_BITS-1:0]     sym_c;
  logic                    gt_c, lt_c;
  logic signed [WEIGHT_BITS:0] wsum [NUM_PRED];
  logic [NB_BITS-1:0]      nb_c;
  logic [ERR_BITS+2:0]     esum;
  logic [ERR_BITS-1:0]     err_c;

  // packing terms
  logic [SYM_BITS-1:0]     nz, rem, code, code2, mask_nb;
  logic                    a_emit, b_emit, c_emit;
  logic [CNT_BITS-1:0]     b_cnt;
  logic [5:0]              nz2;
  logic [WORD_BITS-1:0]    cache1, cache2, cache3, word_c;
  logic [FREE_BITS-1:0]    free1, free2, free3;
  logic [LEN_BITS-1:0]     len, len2;
  result_t                 res [MAX_RES];
  logic [MAX_RES-1:0]      res_v;
  logic [FIFO_AW-1:0]      wr_idx [MAX_RES];
  logic [2:0]              n_push;

  function automatic logic [NB_BITS-1:0] msb_index(input logic [ERR_BITS:0] v);
    logic [NB_BITS-1:0] r;
    r = '0;
    for (int i = 1; i <= ERR_BITS; i++) begin
      if (v[i]) r = NB_BITS'(i);
    end
    return r;
  endfunction

  // effective row width
  always_comb begin
    if (width_r == '0) begin
      w_eff = COL_BITS'(1);
    end else if (width_r > CFG_BITS'(MAX_WIDTH)) begin
      w_eff = COL_BITS'(MAX_WIDTH);
    end else begin
      w_eff = COL_BITS'(width_r);
    end
  end

  assign col_p3    = (COL_BITS + 1)'(col_r) + (COL_BITS + 1)'(3);
  assign col_p1    = (COL_BITS + 1)'(col_r) + (COL_BITS + 1)'(1);
  assign need_roll = col_r >= w_eff;

  // north neighbours past the row end read zero under the width in use now
  assign p3_in_row = col_p3 < (COL_BITS + 1)'(w_eff);
  assign ne_g      = (col_p1 < (COL_BITS + 1)'(w_eff)) ? win_ne_r : '0;

  assign in_stream.ready = (state_r == ST_IDLE) && !need_roll &&
                           (count_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2 * MAX_RES));
  assign accept = in_stream.valid && in_stream.ready;

  // neighbour predictors and weight products, registered at accept
  always_comb begin
    est_c[0] = EST_BITS'(win_n_r) + EST_BITS'(west_pix_r) - EST_BITS'(win_nw_r);
    est_c[1] = EST_BITS'(win_n_r);
    est_c[2] = EST_BITS'(west_pix_r);
    est_c[3] = EST_BITS'(west_pix_r) + EST_BITS'(ne_g) - EST_BITS'(win_n_r);
    for (int j = 0; j < NUM_PRED; j++) begin
      prod_c[j] = PROD_BITS'(weight_r[j]) * PROD_BITS'(est_c[j]);
    end
  end

  // blend, clamp, residual, weight update
  always_comb begin
    nrd      = rd_gate_r ? ram_rdata : '0;
    neee_raw = nrd[PIXEL_BITS-1:0];
    neee     = p3_in_row ? neee_raw : '0;
    eneee    = p3_in_row ? nrd[RAM_BITS-1:PIXEL_BITS] : '0;

    vmin = (win_n_r < west_pix_r) ? win_n_r : west_pix_r;
    vmax = (win_n_r < west_pix_r) ? west_pix_r : win_n_r;
    if (ne_g < vmin) vmin = ne_g;
    if (ne_g > vmax) vmax = ne_g;
    if (neee < vmin) vmin = neee;
    if (neee > vmax) vmax = neee;

    sum_c = (SUM_BITS'(1) <<< (WEIGHT_FRAC_BITS - 1)) + SUM_BITS'(prod_r[0]) +
            SUM_BITS'(prod_r[1]) + SUM_BITS'(prod_r[2]) + SUM_BITS'(prod_r[3]);
    p0_c   = sum_c[SUM_BITS-1:WEIGHT_FRAC_BITS];
    curr_s = P0_BITS'(cur_pix_r);
    vmin_s = P0_BITS'(vmin);
    vmax_s = P0_BITS'(vmax);

    if (p0_c < vmin_s) begin
      pred_c = vmin;
    end else if (p0_c > vmax_s) begin
      pred_c = vmax;
    end else begin
      pred_c = p0_c[PIXEL_BITS-1:0];
    end

    d_c   = (PIXEL_BITS + 1)'(cur_pix_r) - (PIXEL_BITS + 1)'(pred_c);
    sym_c = {d_c, 1'b0} ^ {SYM_BITS{d_c[PIXEL_BITS]}};

    gt_c = curr_s > p0_c;
    lt_c = curr_s < p0_c;
    for (int j = 0; j < NUM_PRED; j++) begin
      if (gt_c) begin
        wsum[j] = (WEIGHT_BITS + 1)'(weight_r[j]) + (WEIGHT_BITS + 1)'(est_r[j]);
      end else if (lt_c) begin
        wsum[j] = (WEIGHT_BITS + 1)'(weight_r[j]) - (WEIGHT_BITS + 1)'(est_r[j]);
      end else begin
        wsum[j] = (WEIGHT_BITS + 1)'(weight_r[j]);
      end
    end

    nb_c  = msb_index((ERR_BITS + 1)'(west_err_r) + (ERR_BITS + 1)'(1));
    esum  = ((ERR_BITS + 3)'(west_err_r) << 1) + (ERR_BITS + 3)'(sym_c) +
            (ERR_BITS + 3)'(eneee);
    err_c = esum[ERR_BITS+1:2];
  end

  // rice code packing: zero run, stop bit and low bits, optional flush
  always_comb begin
    nz      = pk_sym_r >> pk_nb_r;
    a_emit  = nz >= SYM_BITS'(free_r);
    rem     = nz - SYM_BITS'(free_r);
    b_emit  = a_emit && (rem[SYM_BITS-1:6] != '0);
    b_cnt   = CNT_BITS'(rem >> 6);
    nz2     = a_emit ? rem[5:0] : nz[5:0];
    cache1  = a_emit ? '0 : cache_r;
    free1   = (a_emit ? FULL_FREE : free_r) - FREE_BITS'(nz2);

    mask_nb = (SYM_BITS'(1) << pk_nb_r) - SYM_BITS'(1);
    code    = (SYM_BITS'(1) << pk_nb_r) | (pk_sym_r & mask_nb);
    len     = LEN_BITS'(pk_nb_r) + LEN_BITS'(1);
    c_emit  = FREE_BITS'(len) >= free1;
    len2    = c_emit ? (len - LEN_BITS'(free1)) : len;
    word_c  = cache1 | WORD_BITS'(code >> len2);
    code2   = code & ((SYM_BITS'(1) << len2) - SYM_BITS'(1));
    cache2  = c_emit ? '0 : cache1;
    free2   = c_emit ? FULL_FREE : free1;
    free3   = free2 - FREE_BITS'(len2);
    cache3  = cache2 | (WORD_BITS'(code2) << free3);

    // word completed by zeros; a following zero run folds into it when it is empty
    res[0].word         = cache_r;
    res[0].repeat_count = (cache_r == '0 && b_emit) ? b_cnt + CNT_BITS'(1) : CNT_BITS'(1);
    res[0].last_word    = 1'b0;
    res[1].word         = '0;
    res[1].repeat_count = b_cnt;
    res[1].last_word    = 1'b0;
    res[2].word         = word_c;
    res[2].repeat_count = CNT_BITS'(1);
    res[2].last_word    = 1'b0;
    res[3].word         = cache3;
    res[3].repeat_count = CNT_BITS'(1);
    res[3].last_word    = 1'b1;

    res_v[0] = pk_v_r && a_emit;
    res_v[1] = pk_v_r && b_emit && (cache_r != '0);
    res_v[2] = pk_v_r && c_emit;
    res_v[3] = pk_v_r && pk_eoi_r;

    n_push = '0;
    for (int j = 0; j < MAX_RES; j++) begin
      wr_idx[j] = wr_ptr_r + FIFO_AW'(n_push);
      n_push    = n_push + 3'(res_v[j]);
    end
  end

  // result queue head drives the output channel
  assign out_stream.valid        = count_r != '0;
  assign out_stream.word         = fifo_r[rd_ptr_r].word;
  assign out_stream.repeat_count = fifo_r[rd_ptr_r].repeat_count;
  assign out_stream.last_word    = fifo_r[rd_ptr_r].last_word;
  assign pop = out_stream.valid && out_stream.ready;

  // row memory: north reads from the other half, writes to the current half; clear writes every entry
  assign rd_idx    = (state_r == ST_PREF) ? IDX_BITS'(pf_cnt_r) : IDX_BITS'(col_p3);
  assign ram_raddr = {~parity_r, rd_idx};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {parity_r, col_r[IDX_BITS-1:0]};
    ram_wdata = {err_c, cur_pix_r};
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      ST_CALC: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lpr_ram #(
    .WIDTH (RAM_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    width_nxt     = cfg_we ? cfg_wdata : width_r;
    col_nxt       = col_r;
    parity_nxt    = parity_r;
    first_row_nxt = first_row_r;
    clr_cnt_nxt   = clr_cnt_r;
    pf_cnt_nxt    = pf_cnt_r;
    win_nw_nxt    = win_nw_r;
    win_n_nxt     = win_n_r;
    win_ne_nxt    = win_ne_r;
    win_nn2_nxt   = win_nn2_r;
    west_pix_nxt  = west_pix_r;
    west_err_nxt  = west_err_r;
    for (int j = 0; j < NUM_PRED; j++) begin
      weight_nxt[j] = weight_r[j];
    end
    pk_v_nxt = 1'b0;

    // gate of the read issued this cycle: the first row has no north neighbours
    rd_gate_nxt = !first_row_r;

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_BITS'(1);
        if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (need_roll) begin
          // width shrank under the current column: start a new row
          col_nxt       = '0;
          parity_nxt    = ~parity_r;
          first_row_nxt = 1'b0;
          win_nw_nxt    = '0;
          win_n_nxt     = '0;
          win_ne_nxt    = '0;
          win_nn2_nxt   = '0;
          west_pix_nxt  = '0;
          west_err_nxt  = '0;
          pf_cnt_nxt    = '0;
          state_nxt     = ST_PREF;
        end else if (accept) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        pk_v_nxt = 1'b1;
        for (int j = 0; j < NUM_PRED; j++) begin
          if (wsum[j][WEIGHT_BITS] != wsum[j][WEIGHT_BITS-1]) begin
            weight_nxt[j] = wsum[j][WEIGHT_BITS] ? {1'b1, {(WEIGHT_BITS - 1){1'b0}}}
                                                 : {1'b0, {(WEIGHT_BITS - 1){1'b1}}};
          end else begin
            weight_nxt[j] = wsum[j][WEIGHT_BITS-1:0];
          end
        end
        win_nw_nxt   = win_n_r;
        win_n_nxt    = win_ne_r;
        win_ne_nxt   = win_nn2_r;
        win_nn2_nxt  = neee_raw;
        west_pix_nxt = cur_pix_r;
        west_err_nxt = err_c;
        col_nxt      = COL_BITS'(col_p1);
        state_nxt    = ST_IDLE;
        if (cur_eoi_r) begin
          for (int j = 0; j < NUM_PRED; j++) begin
            weight_nxt[j] = WEIGHT_INIT;
          end
          col_nxt       = '0;
          parity_nxt    = 1'b0;
          first_row_nxt = 1'b1;
          win_nw_nxt    = '0;
          win_n_nxt     = '0;
          win_ne_nxt    = '0;
          win_nn2_nxt   = '0;
          west_pix_nxt  = '0;
          west_err_nxt  = '0;
          clr_cnt_nxt   = '0;
          state_nxt     = ST_CLEAR;
        end else if (col_p1 >= (COL_BITS + 1)'(w_eff)) begin
          col_nxt       = '0;
          parity_nxt    = ~parity_r;
          first_row_nxt = 1'b0;
          win_nw_nxt    = '0;
          win_n_nxt     = '0;
          win_ne_nxt    = '0;
          win_nn2_nxt   = '0;
          west_pix_nxt  = '0;
          west_err_nxt  = '0;
          pf_cnt_nxt    = '0;
          state_nxt     = ST_PREF;
        end
      end
      ST_PREF: begin
        // three reads of the previous row, each shifted in the cycle after it is issued
        pf_cnt_nxt = pf_cnt_r + 2'd1;
        if (pf_cnt_r != 2'd0) begin
          win_nw_nxt  = win_n_r;
          win_n_nxt   = win_ne_r;
          win_ne_nxt  = win_nn2_r;
          win_nn2_nxt = neee_raw;
        end
        if (pf_cnt_r == 2'd3) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    if (pk_v_r) begin
      cache_nxt = pk_eoi_r ? '0 : cache3;
      free_nxt  = pk_eoi_r ? FULL_FREE : free3;
    end else begin
      cache_nxt = cache_r;
      free_nxt  = free_r;
    end

    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(n_push);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + (FIFO_AW + 1)'(n_push) - (FIFO_AW + 1)'(pop);
  end

  // control and image state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      width_r     <= WIDTH_RESET;
      col_r       <= '0;
      parity_r    <= 1'b0;
      first_row_r <= 1'b1;
      clr_cnt_r   <= '0;
      pf_cnt_r    <= '0;
      rd_gate_r   <= 1'b0;
      for (int j = 0; j < NUM_PRED; j++) begin
        weight_r[j] <= WEIGHT_INIT;
      end
      win_nw_r    <= '0;
      win_n_r     <= '0;
      win_ne_r    <= '0;
      win_nn2_r   <= '0;
      west_pix_r  <= '0;
      west_err_r  <= '0;
      pk_v_r      <= 1'b0;
      cache_r     <= '0;
      free_r      <= FULL_FREE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      col_r       <= col_nxt;
      parity_r    <= parity_nxt;
      first_row_r <= first_row_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pf_cnt_r    <= pf_cnt_nxt;
      rd_gate_r   <= rd_gate_nxt;
      for (int j = 0; j < NUM_PRED; j++) begin
        weight_r[j] <= weight_nxt[j];
      end
      win_nw_r    <= win_nw_nxt;
      win_n_r     <= win_n_nxt;
      win_ne_r    <= win_ne_nxt;
      win_nn2_r   <= win_nn2_nxt;
      west_pix_r  <= west_pix_nxt;
      west_err_r  <= west_err_nxt;
      pk_v_r      <= pk_v_nxt;
      cache_r     <= cache_nxt;
      free_r      <= free_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_pix_r <= in_stream.pixel;
      cur_eoi_r <= in_stream.end_of_image;
      for (int j = 0; j < NUM_PRED; j++) begin
        est_r[j]  <= est_c[j];
        prod_r[j] <= prod_c[j];
      end
    end
    if (state_r == ST_CALC) begin
      pk_sym_r <= sym_c;
      pk_nb_r  <= nb_c;
      pk_eoi_r <= cur_eoi_r;
    end
    for (int j = 0; j < MAX_RES; j++) begin
      if (res_v[j]) fifo_r[wr_idx[j]] <= res[j];
    end
  end

  // checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue over capacity");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    pk_v_r |-> ((FIFO_AW + 2)'(count_r) + (FIFO_AW + 2)'(n_push) <=
                (FIFO_AW + 2)'(FIFO_DEPTH)))
    else $error("packing results overflow the queue");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR || state_r == ST_PREF) |-> !accept)
    else $error("pixel taken during clear or prefetch");

  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_stream.valid && out_stream.last_word) |-> (out_stream.repeat_count == CNT_BITS'(1)))
    else $error("flush word with repeat count");

  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_stream.valid && out_stream.repeat_count > CNT_BITS'(1)) |-> (out_stream.word == '0))
    else $error("repeated word is not zero");

endmodule
